// File: sv/assert_macros.svh
// assert_macros.svh
// Assertion macros for the checker file of the rolling hash search.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rolling hash search: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rolling hash search: next-cycle check failed");

`endif

// File: sv/rhs_pkg.sv
// rhs_pkg.sv
// Shared types, constants, modular reduction tables and hash step function
// for the rolling hash substring search. No dependencies.
package rhs_pkg;

  localparam int MAX_NEEDLE_DEF = 64;
  localparam int SYM_W  = 8;
  localparam int POS_W  = 32;
  localparam int HASH_W = 30;
  // An 8-bit digit magnitude times a residue below 2^30.
  localparam int PROD_W = HASH_W + SYM_W;
  // Radix times a residue plus a residue stays below 28 primes, under 2^35.
  localparam int ROLL_W = 35;
  localparam int TAB_N  = 256;
  // Queue between front and back; a power of two.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [HASH_W-1:0] PRIME_A = 30'd1000000007;
  localparam logic [HASH_W-1:0] PRIME_B = 30'd1000000033;
  localparam logic [4:0] RADIX_A = 5'd26;
  localparam logic [4:0] RADIX_B = 5'd27;
  localparam logic [SYM_W-1:0] CHAR_BASE = 8'd97;

  // Command codes on the request channel.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_NEEDLE = 2'd1;
  localparam logic [1:0] CMD_HAY    = 2'd2;

  // What the front hands to the back.
  typedef enum logic [1:0] {
    K_CLEAR,
    K_NEEDLE,
    K_HAY,
    K_FIXED
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SYM_W-1:0]  sym;
    logic [SYM_W-1:0]  old;    // byte leaving the window
    logic              full;   // window was full before this byte
    logic              chk;    // window is full after this byte
    logic              last;
    logic [POS_W-1:0]  pos;    // start of the window ending at this byte
    logic              found;  // outcome of a fixed result
    logic              ovf;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t data;
  } push_t;

  typedef struct packed {
    logic   empty;
    entry_t data;
  } head_t;

  typedef logic [ROLL_W-1:0] qp_tab_t [TAB_N];
  typedef logic [HASH_W-1:0] fold_tab_t [TAB_N];

  // Entry i holds the largest multiple of p not above i * 2^(ROLL_W-8).
  function automatic qp_tab_t build_qp(input logic [HASH_W-1:0] p);
    qp_tab_t t;
    logic [ROLL_W-1:0] lo;
    logic [ROLL_W-1:0] acc;
    for (int i = 0; i < TAB_N; i++) begin
      lo  = ROLL_W'(i) << (ROLL_W - 8);
      acc = '0;
      for (int k = 0; k < 40; k++) begin
        if (acc + ROLL_W'(p) <= lo) acc = acc + ROLL_W'(p);
      end
      t[i] = acc;
    end
    return t;
  endfunction

  // Entry i holds (i * 2^HASH_W) mod p.
  function automatic fold_tab_t build_fold(input logic [HASH_W-1:0] p);
    fold_tab_t t;
    logic [HASH_W:0] v;
    logic [HASH_W:0] step;
    step = (HASH_W+1)'(1) << HASH_W;
    step = step - (HASH_W+1)'(p);
    v = '0;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = v[HASH_W-1:0];
      v = v + step;
      if (v >= (HASH_W+1)'(p)) v = v - (HASH_W+1)'(p);
    end
    return t;
  endfunction

  localparam qp_tab_t   QP_A   = build_qp(PRIME_A);
  localparam qp_tab_t   QP_B   = build_qp(PRIME_B);
  localparam fold_tab_t FOLD_A = build_fold(PRIME_A);
  localparam fold_tab_t FOLD_B = build_fold(PRIME_B);

  // (r*h + d) mod p for h, d below p: the top bits pick the quotient to
  // within one, and a single compare-subtract finishes.
  function automatic logic [HASH_W-1:0] mod_roll(input logic [HASH_W-1:0] h,
                                                 input logic [HASH_W-1:0] d,
                                                 input logic [4:0] r,
                                                 input qp_tab_t qp,
                                                 input logic [HASH_W-1:0] p);
    logic [ROLL_W-1:0] x;
    logic [ROLL_W-1:0] y;
    x = ROLL_W'(h) * ROLL_W'(r) + ROLL_W'(d);
    y = x - qp[x[ROLL_W-1 -: 8]];
    if (y >= ROLL_W'(p)) y = y - ROLL_W'(p);
    return y[HASH_W-1:0];
  endfunction

endpackage

// File: sv/rhs_fifo.sv
// rhs_fifo.sv
// Short queue that decouples the request front from the hashing back end.
// Depends on rhs_pkg.
module rhs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  rhs_pkg::push_t wr,
  output logic           full,
  input  logic           pop,
  output rhs_pkg::head_t head
);
  import rhs_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head.empty = (count == '0);
  assign head.data  = mem[rd_ptr];
  assign do_push    = wr.push && !full;
  assign do_pop     = pop && !head.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr.data;
  end

endmodule

// File: sv/rhs_front.sv
// rhs_front.sv
// Request front: classifies commands, tracks lengths and the window ring,
// and hands work items to the queue. Depends on rhs_pkg.
module rhs_front #(
  parameter int MAX_NEEDLE = rhs_pkg::MAX_NEEDLE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [1:0]                cmd,
  input  logic [rhs_pkg::SYM_W-1:0] symbol,
  input  logic                      last,
  input  logic                      q_full,
  output rhs_pkg::push_t            q_push
);
  import rhs_pkg::*;

  localparam int PTR_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

  logic [LEN_W-1:0] needle_length, needle_length_next;
  logic [POS_W-1:0] bytes_seen, bytes_seen_next;
  logic [PTR_W-1:0] ring_pointer, ring_pointer_next;
  logic             length_overflow, length_overflow_next;
  logic             fixed_done, fixed_done_next;
  logic             stage_valid;
  entry_t           stage;
  entry_t           ent;
  logic             keep;
  logic             ring_we;
  logic             acc;
  logic [POS_W-1:0] seen_inc;
  logic [PTR_W:0]   ptr_inc;

  logic [SYM_W-1:0] ring [MAX_NEEDLE];
  logic [SYM_W-1:0] ring_rd;

  assign req_stall = stage_valid && q_full;
  assign acc       = req_valid && !req_stall;

  always_comb begin
    q_push.push     = stage_valid && !q_full;
    q_push.data     = stage;
    q_push.data.old = ring_rd;
  end

  always_comb begin
    ent                  = '0;
    ent.sym              = symbol;
    ent.last             = last;
    keep                 = 1'b0;
    ring_we              = 1'b0;
    needle_length_next   = needle_length;
    bytes_seen_next      = bytes_seen;
    ring_pointer_next    = ring_pointer;
    length_overflow_next = length_overflow;
    fixed_done_next      = fixed_done;
    seen_inc = (bytes_seen == '1) ? bytes_seen : bytes_seen + 1'b1;
    ptr_inc  = {1'b0, ring_pointer} + 1'b1;
    case (cmd)
      CMD_CLEAR: begin
        keep                 = 1'b1;
        ent.kind             = K_CLEAR;
        needle_length_next   = '0;
        bytes_seen_next      = '0;
        ring_pointer_next    = '0;
        length_overflow_next = 1'b0;
        fixed_done_next      = 1'b0;
      end
      CMD_NEEDLE: begin
        if (!fixed_done && bytes_seen == '0) begin
          if (needle_length >= LEN_W'(MAX_NEEDLE)) begin
            length_overflow_next = 1'b1;
          end else begin
            keep               = 1'b1;
            ent.kind           = K_NEEDLE;
            needle_length_next = needle_length + 1'b1;
          end
        end
      end
      CMD_HAY: begin
        if (!fixed_done) begin
          if (length_overflow) begin
            if (last) begin
              keep            = 1'b1;
              ent.kind        = K_FIXED;
              ent.ovf         = 1'b1;
              fixed_done_next = 1'b1;
            end
          end else if (needle_length == '0) begin
            keep            = 1'b1;
            ent.kind        = K_FIXED;
            ent.found       = 1'b1;
            fixed_done_next = 1'b1;
          end else begin
            keep            = 1'b1;
            ent.kind        = K_HAY;
            ent.full        = (bytes_seen >= POS_W'(needle_length));
            ent.chk         = (seen_inc >= POS_W'(needle_length));
            ent.pos         = seen_inc - POS_W'(needle_length);
            ring_we         = 1'b1;
            bytes_seen_next = seen_inc;
            if ((LEN_W+1)'(ptr_inc) >= (LEN_W+1)'(needle_length)) begin
              ring_pointer_next = '0;
            end else begin
              ring_pointer_next = ptr_inc[PTR_W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid     <= 1'b0;
      needle_length   <= '0;
      bytes_seen      <= '0;
      ring_pointer    <= '0;
      length_overflow <= 1'b0;
      fixed_done      <= 1'b0;
    end else begin
      if (acc) begin
        stage_valid     <= keep;
        needle_length   <= needle_length_next;
        bytes_seen      <= bytes_seen_next;
        ring_pointer    <= ring_pointer_next;
        length_overflow <= length_overflow_next;
        fixed_done      <= fixed_done_next;
      end else if (q_push.push) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) stage <= ent;
  end

  // Ring read returns the byte stored before this write.
  always_ff @(posedge clk) begin
    if (acc) begin
      ring_rd <= ring[ring_pointer];
      if (ring_we) ring[ring_pointer] <= symbol;
    end
  end

endmodule

// File: sv/rhs_back.sv
// rhs_back.sv
// Hashing back end: seven-stage pipeline that removes the outgoing byte,
// rolls both hashes, compares with the needle and drives the result register.
// Depends on rhs_pkg.
module rhs_back (
  input  logic                      clk,
  input  logic                      rst,
  input  rhs_pkg::head_t            head,
  output logic                      pop,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic                      found,
  output logic [rhs_pkg::POS_W-1:0] position,
  output logic                      overflow_error
);
  import rhs_pkg::*;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic             chk;
    logic             last;
    logic [POS_W-1:0] pos;
    logic             found;
    logic             ovf;
  } tag_t;

  logic adv;

  tag_t s1, s2, s3, s4, s5, s6, s7;
  tag_t t_in;

  logic [SYM_W-1:0]  sym1, old1;
  logic              full1;
  logic [PROD_W-1:0] prod_a2, prod_b2;
  logic              neg2, neg3, neg4;
  logic signed [8:0] e2, e3, e4;
  logic [HASH_W:0]   r1_a3, r1_b3;
  logic [HASH_W-1:0] mr_a4, mr_b4;
  logic signed [31:0] t_a5, t_b5;
  logic [HASH_W-1:0] d_a6, d_b6;

  logic [HASH_W-1:0] top_a, top_b;
  logic [HASH_W-1:0] needle_a, needle_b;
  logic [HASH_W-1:0] window_a, window_b;
  logic              search_done;

  logic signed [8:0]  od1, e1;
  logic [SYM_W-1:0]   mag1;
  logic               neg1;
  logic [PROD_W-1:0]  prod_a1, prod_b1;
  logic [HASH_W:0]    r1_a2, r1_b2;
  logic [HASH_W-1:0]  mr_a3, mr_b3;
  logic [HASH_W:0]    t0_a4, t0_b4;
  logic signed [31:0] t_a4, t_b4;
  logic [HASH_W-1:0]  d_a5, d_b5;
  logic               match7, emit7, found7, ovf7;
  logic [POS_W-1:0]   pos7;

  assign adv = !(rsp_valid && rsp_stall);
  assign pop = adv && !head.empty;

  always_comb begin
    t_in       = '0;
    t_in.valid = !head.empty;
    t_in.kind  = head.data.kind;
    t_in.chk   = head.data.chk;
    t_in.last  = head.data.last;
    t_in.pos   = head.data.pos;
    t_in.found = head.data.found;
    t_in.ovf   = head.data.ovf;
  end

  // Stage 1: signed digit of the outgoing byte times the top weight.
  always_comb begin
    od1     = $signed({1'b0, old1}) - $signed({1'b0, CHAR_BASE});
    e1      = $signed({1'b0, sym1}) - $signed({1'b0, CHAR_BASE});
    neg1    = full1 && od1[8];
    mag1    = !full1 ? '0 : (od1[8] ? SYM_W'(-od1) : od1[SYM_W-1:0]);
    prod_a1 = PROD_W'(mag1) * PROD_W'(top_a);
    prod_b1 = PROD_W'(mag1) * PROD_W'(top_b);
  end

  // Stage 2: fold bits above 2^30 through the residue table.
  always_comb begin
    r1_a2 = (HASH_W+1)'(FOLD_A[prod_a2[PROD_W-1 -: 8]]) + (HASH_W+1)'(prod_a2[HASH_W-1:0]);
    r1_b2 = (HASH_W+1)'(FOLD_B[prod_b2[PROD_W-1 -: 8]]) + (HASH_W+1)'(prod_b2[HASH_W-1:0]);
  end

  // Stage 3: the folded value is below three primes.
  always_comb begin
    if (r1_a3 >= ((HASH_W+1)'(PRIME_A) << 1)) begin
      mr_a3 = HASH_W'(r1_a3 - ((HASH_W+1)'(PRIME_A) << 1));
    end else if (r1_a3 >= (HASH_W+1)'(PRIME_A)) begin
      mr_a3 = HASH_W'(r1_a3 - (HASH_W+1)'(PRIME_A));
    end else begin
      mr_a3 = r1_a3[HASH_W-1:0];
    end
    if (r1_b3 >= ((HASH_W+1)'(PRIME_B) << 1)) begin
      mr_b3 = HASH_W'(r1_b3 - ((HASH_W+1)'(PRIME_B) << 1));
    end else if (r1_b3 >= (HASH_W+1)'(PRIME_B)) begin
      mr_b3 = HASH_W'(r1_b3 - (HASH_W+1)'(PRIME_B));
    end else begin
      mr_b3 = r1_b3[HASH_W-1:0];
    end
  end

  // Stage 4: negate the outgoing term and add the incoming digit.
  always_comb begin
    t0_a4 = neg4 ? (HASH_W+1)'(mr_a4) : (HASH_W+1)'(PRIME_A) - (HASH_W+1)'(mr_a4);
    t0_b4 = neg4 ? (HASH_W+1)'(mr_b4) : (HASH_W+1)'(PRIME_B) - (HASH_W+1)'(mr_b4);
    t_a4  = $signed({1'b0, t0_a4}) + 32'(e4);
    t_b4  = $signed({1'b0, t0_b4}) + 32'(e4);
  end

  // Stage 5: bring the difference back into the residue range.
  always_comb begin
    if (t_a5 < 0) begin
      d_a5 = HASH_W'(t_a5 + $signed({2'b00, PRIME_A}));
    end else if (t_a5 >= $signed({2'b00, PRIME_A})) begin
      d_a5 = HASH_W'(t_a5 - $signed({2'b00, PRIME_A}));
    end else begin
      d_a5 = HASH_W'(t_a5);
    end
    if (t_b5 < 0) begin
      d_b5 = HASH_W'(t_b5 + $signed({2'b00, PRIME_B}));
    end else if (t_b5 >= $signed({2'b00, PRIME_B})) begin
      d_b5 = HASH_W'(t_b5 - $signed({2'b00, PRIME_B}));
    end else begin
      d_b5 = HASH_W'(t_b5);
    end
  end

  // Stage 7: compare and decide on a result.
  always_comb begin
    match7 = (window_a == needle_a) && (window_b == needle_b);
    emit7  = 1'b0;
    found7 = 1'b0;
    pos7   = '0;
    ovf7   = 1'b0;
    if (s7.valid && !search_done) begin
      case (s7.kind)
        K_FIXED: begin
          emit7  = 1'b1;
          found7 = s7.found;
          ovf7   = s7.ovf;
        end
        K_HAY: begin
          if (s7.chk && match7) begin
            emit7  = 1'b1;
            found7 = 1'b1;
            pos7   = s7.pos;
          end else if (s7.last) begin
            emit7 = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1          <= '0;
      s2          <= '0;
      s3          <= '0;
      s4          <= '0;
      s5          <= '0;
      s6          <= '0;
      s7          <= '0;
      top_a       <= HASH_W'(1);
      top_b       <= HASH_W'(1);
      needle_a    <= '0;
      needle_b    <= '0;
      window_a    <= '0;
      window_b    <= '0;
      search_done <= 1'b0;
      rsp_valid   <= 1'b0;
    end else if (adv) begin
      s1 <= t_in;
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
      s5 <= s4;
      s6 <= s5;
      s7 <= s6;
      if (s1.valid && s1.kind == K_CLEAR) begin
        top_a <= HASH_W'(1);
        top_b <= HASH_W'(1);
      end else if (s1.valid && s1.kind == K_NEEDLE) begin
        top_a <= mod_roll(top_a, '0, RADIX_A, QP_A, PRIME_A);
        top_b <= mod_roll(top_b, '0, RADIX_B, QP_B, PRIME_B);
      end
      if (s6.valid) begin
        case (s6.kind)
          K_CLEAR: begin
            needle_a <= '0;
            needle_b <= '0;
            window_a <= '0;
            window_b <= '0;
          end
          K_NEEDLE: begin
            needle_a <= mod_roll(needle_a, d_a6, RADIX_A, QP_A, PRIME_A);
            needle_b <= mod_roll(needle_b, d_b6, RADIX_B, QP_B, PRIME_B);
          end
          K_HAY: begin
            window_a <= mod_roll(window_a, d_a6, RADIX_A, QP_A, PRIME_A);
            window_b <= mod_roll(window_b, d_b6, RADIX_B, QP_B, PRIME_B);
          end
          default: begin
          end
        endcase
      end
      if (s7.valid && s7.kind == K_CLEAR) begin
        search_done <= 1'b0;
      end else if (emit7) begin
        search_done <= 1'b1;
      end
      rsp_valid <= emit7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sym1    <= head.data.sym;
      old1    <= head.data.old;
      full1   <= head.data.full;
      prod_a2 <= prod_a1;
      prod_b2 <= prod_b1;
      neg2    <= neg1;
      e2      <= e1;
      r1_a3   <= r1_a2;
      r1_b3   <= r1_b2;
      neg3    <= neg2;
      e3      <= e2;
      mr_a4   <= mr_a3;
      mr_b4   <= mr_b3;
      neg4    <= neg3;
      e4      <= e3;
      t_a5    <= t_a4;
      t_b5    <= t_b4;
      d_a6    <= d_a5;
      d_b6    <= d_b5;
      if (emit7) begin
        found          <= found7;
        position       <= pos7;
        overflow_error <= ovf7;
      end
    end
  end

endmodule

// File: sv/rolling_hash_substring_search.sv
// rolling_hash_substring_search.sv
// Top level of the double rolling hash substring search.
// Depends on rhs_pkg, rhs_front, rhs_fifo and rhs_back.
//
// Usage: each search starts with a clear request (cmd 0), then the needle
// bytes (cmd 1), then the haystack bytes (cmd 2), the final one flagged by
// last. A request is taken at a rising edge where req_valid is high and
// req_stall is low. At most one result per search comes out on the result
// channel (rsp_valid, rsp_stall): found with the start position of the first
// window whose two hashes both equal the needle's, or a not-found result on
// the last byte. overflow_error is set when the needle exceeded MAX_NEEDLE.
// Throughput is one request per cycle while req_stall is low; the
// recurrences are the modular rolls of the top weights in the back end's
// first stage and of the needle and window hashes in its sixth stage. An
// accepted request passes through one front stage, one queue slot and seven
// back stages on its way to the result register. A stalled result freezes
// the back pipeline; the four-entry queue and the front stage keep taking
// requests until they fill, and only then is req_stall raised. Reset clears
// all counters, hashes (weights to one) and the result valid. The window
// ring is not cleared: every entry is written before its byte is used.
module rolling_hash_substring_search #(
  parameter int MAX_NEEDLE = rhs_pkg::MAX_NEEDLE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [1:0]                cmd,
  input  logic [rhs_pkg::SYM_W-1:0] symbol,
  input  logic                      last,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic                      found,
  output logic [rhs_pkg::POS_W-1:0] position,
  output logic                      overflow_error
);
  import rhs_pkg::*;

  push_t q_push;
  head_t q_head;
  logic  q_full;
  logic  q_pop;

  // The front classifies requests and keeps the lengths and window ring.
  rhs_front #(
    .MAX_NEEDLE(MAX_NEEDLE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .symbol    (symbol),
    .last      (last),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  // The queue lets the front keep going while the back end holds a result.
  rhs_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .full (q_full),
    .pop  (q_pop),
    .head (q_head)
  );

  // The back end does all hashing and owns the result register.
  rhs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (q_head),
    .pop            (q_pop),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .found          (found),
    .position       (position),
    .overflow_error (overflow_error)
  );

endmodule

// File: sv/rhs_checker.sv
// rhs_checker.sv
// Port-level checks on the rolling hash search, bound to its top level.
// Depends on assert_macros.svh and rolling_hash_substring_search.
`include "assert_macros.svh"

module rhs_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic        found,
  input logic [31:0] position,
  input logic        overflow_error
);

  // A held result keeps its contents.
  `RHS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(found) && $stable(position) && $stable(overflow_error))

  // A not-found result carries position zero.
  `RHS_ASSERT_IMP(a_notfound_pos, rsp_valid && !found, position == 32'd0)

  // An overlong needle can never produce a match.
  `RHS_ASSERT_IMP(a_ovf_notfound, rsp_valid && overflow_error, !found)

  // No result is shown in the cycle after reset.
  `RHS_ASSERT_IMP(a_reset_quiet, $past(rst), !rsp_valid)

endmodule

bind rolling_hash_substring_search rhs_checker u_rhs_checker (.*);

// File: dv/rolling_hash_substring_search_tb.sv
// Self-checking testbench for the double rolling hash substring search.
// Needs rhs_pkg and the rolling_hash_substring_search RTL; predicts each result
// with its own modular hash model and compares it field by field.
module rolling_hash_substring_search_tb;
  import rhs_pkg::*;

  localparam int NEEDLE_CAP = MAX_NEEDLE_DEF;
  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 6;
  // The pipeline depth plus queue slack, taken a few times over.
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_PRINTED = 100;
  localparam longint TIMEOUT_TIME = 64'd8_000_000;
  // The block ignores this command code.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             ovf;
  } search_result_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  logic [1:0]       cmd = CMD_CLEAR;
  logic [SYM_W-1:0] symbol = '0;
  logic             last = 1'b0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic             found;
  logic [POS_W-1:0] position;
  logic             overflow_error;

  rolling_hash_substring_search #(
    .MAX_NEEDLE(NEEDLE_CAP)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .cmd           (cmd),
    .symbol        (symbol),
    .last          (last),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .found         (found),
    .position      (position),
    .overflow_error(overflow_error)
  );

  // Idling knobs: percentage of cycles in which the request side holds off
  // and the result side stalls. Each test phase sets them.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned mismatch_count = 0;

  // Results the search model has produced and the block still owes us.
  search_result_t expected_results[$];

  // Search model state. The recent-byte ring is never cleared, just like the
  // block's; an entry is only used once the window has filled past it.
  logic [HASH_W-1:0] needle_a, needle_b;
  logic [HASH_W-1:0] window_a, window_b;
  logic [HASH_W-1:0] weight_a, weight_b;
  int unsigned       needle_len;
  logic [POS_W-1:0]  hay_count;
  logic [SYM_W-1:0]  recent [NEEDLE_CAP];
  int unsigned       recent_ptr;
  logic              search_closed;
  logic              needle_overflow;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // The run must never take this long; if it does, something has hung.
  initial begin : watchdog
    #(TIMEOUT_TIME);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Modular arithmetic of the search model.
  // ---------------------------------------------------------------------

  // A byte counts as its distance from 'a'; bytes below 'a' wrap to the
  // true negative residue modulo the prime.
  function automatic logic [HASH_W-1:0] char_residue(input logic [SYM_W-1:0] s,
                                                     input logic [HASH_W-1:0] p);
    if (s >= CHAR_BASE) return HASH_W'(s - CHAR_BASE);
    return p - HASH_W'(CHAR_BASE - s);
  endfunction

  function automatic logic [HASH_W-1:0] mul_mod(input longint unsigned x,
                                                input longint unsigned y,
                                                input longint unsigned p);
    return HASH_W'((x * y) % p);
  endfunction

  // One roll of a polynomial hash: shift in a digit and drop the digit that
  // leaves the window, weighted by radix to the needle length.
  function automatic logic [HASH_W-1:0] slide_hash(input longint unsigned h,
                                                   input longint unsigned r,
                                                   input longint unsigned p,
                                                   input longint unsigned outd,
                                                   input longint unsigned top,
                                                   input longint unsigned ind);
    longint unsigned t;
    t = (h * r) % p;
    t = (t + p - (outd * top) % p) % p;
    return HASH_W'((t + ind) % p);
  endfunction

  task automatic clear_search_model();
    needle_a = '0;
    needle_b = '0;
    window_a = '0;
    window_b = '0;
    weight_a = HASH_W'(1);
    weight_b = HASH_W'(1);
    needle_len = 0;
    hay_count = '0;
    recent_ptr = 0;
    search_closed = 1'b0;
    needle_overflow = 1'b0;
  endtask

  // A search reports at most once; after that it is closed until a clear.
  task automatic post_result(input logic f, input logic [POS_W-1:0] pos);
    expected_results.push_back('{found: f, position: pos, ovf: needle_overflow});
    search_closed = 1'b1;
  endtask

  // Advance the search model by one accepted request.
  task automatic step_search_model(input logic [1:0] c, input logic [SYM_W-1:0] s,
                                   input logic l);
    int unsigned       idx;
    logic              filled;
    logic [HASH_W-1:0] out_a, out_b, top_a, top_b;
    if (c == CMD_CLEAR) begin
      clear_search_model();
    end else if (c == CMD_NEEDLE) begin
      // Needle bytes only count before the haystack has begun.
      if (!search_closed && hay_count == 0) begin
        if (needle_len >= NEEDLE_CAP) begin
          needle_overflow = 1'b1;
        end else begin
          needle_a = slide_hash(needle_a, RADIX_A, PRIME_A, 0, 0, char_residue(s, PRIME_A));
          needle_b = slide_hash(needle_b, RADIX_B, PRIME_B, 0, 0, char_residue(s, PRIME_B));
          weight_a = mul_mod(weight_a, RADIX_A, PRIME_A);
          weight_b = mul_mod(weight_b, RADIX_B, PRIME_B);
          needle_len++;
        end
      end
    end else if (c == CMD_HAY && !search_closed) begin
      if (needle_overflow) begin
        if (l) post_result(1'b0, '0);
      end else if (needle_len == 0) begin
        post_result(1'b1, '0);
      end else begin
        idx = recent_ptr % NEEDLE_CAP;
        filled = (hay_count >= needle_len);
        out_a = filled ? char_residue(recent[idx], PRIME_A) : '0;
        out_b = filled ? char_residue(recent[idx], PRIME_B) : '0;
        top_a = filled ? weight_a : '0;
        top_b = filled ? weight_b : '0;
        window_a = slide_hash(window_a, RADIX_A, PRIME_A, out_a, top_a,
                              char_residue(s, PRIME_A));
        window_b = slide_hash(window_b, RADIX_B, PRIME_B, out_b, top_b,
                              char_residue(s, PRIME_B));
        recent[idx] = s;
        recent_ptr = (idx + 1 >= needle_len) ? 0 : idx + 1;
        if (hay_count != '1) hay_count++;
        if (hay_count >= needle_len && window_a == needle_a && window_b == needle_b) begin
          post_result(1'b1, hay_count - POS_W'(needle_len));
        end else if (l) begin
          post_result(1'b0, '0);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Request side.
  // ---------------------------------------------------------------------

  // Send one request. Idle cycles are inserted first at the current rate;
  // then the payload is held until the block takes it, and the model steps.
  // Valid stays high on return so back-to-back requests need no gap.
  task automatic send_req(input logic [1:0] c, input logic [SYM_W-1:0] s, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= c;
    symbol <= s;
    last <= l;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    step_search_model(c, s, l);
    requests_sent++;
  endtask

  // Stop sending and hold off until the block has delivered everything it
  // owes, plus a tail for any request still in flight that gives no result.
  task automatic await_all_results();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic apply_reset();
    clear_search_model();
    rst <= 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Mostly lowercase letters from a small alphabet so that windows collide
  // with the needle often; now and then any byte at all.
  function automatic logic [SYM_W-1:0] pick_symbol(input int unsigned alpha);
    if ($urandom_range(0, 9) == 0) return SYM_W'($urandom_range(0, 255));
    return CHAR_BASE + SYM_W'($urandom_range(0, alpha - 1));
  endfunction

  // ---------------------------------------------------------------------
  // Result side.
  // ---------------------------------------------------------------------

  // Random backpressure on the result channel at the current rate.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
  endtask

  // Every result taken from the block is held against the oldest prediction.
  always @(posedge clk) begin : result_check
    search_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b position=%0d ovf=%0b",
                                  found, position, overflow_error));
      end else begin
        want = expected_results.pop_front();
        if (found !== want.found)
          report_mismatch($sformatf("found %0b, predicted %0b", found, want.found));
        if (position !== want.position)
          report_mismatch($sformatf("position %0d, predicted %0d", position, want.position));
        if (overflow_error !== want.ovf)
          report_mismatch($sformatf("overflow_error %0b, predicted %0b",
                                    overflow_error, want.ovf));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Hand-picked searches: empty needle, a match on the final byte, requests
  // after a search has finished, bytes at both ends of the range, the unused
  // command, a needle byte once the haystack has begun, and a haystack that
  // ends before it is as long as the needle.
  task automatic test_directed();
    send_req(CMD_CLEAR, 8'h00, 1'b0);
    send_req(CMD_HAY, "q", 1'b0);
    send_req(CMD_HAY, "r", 1'b1);

    send_req(CMD_CLEAR, 8'hFF, 1'b1);
    send_req(CMD_NEEDLE, "a", 1'b1);
    send_req(CMD_NEEDLE, "b", 1'b0);
    send_req(CMD_HAY, "z", 1'b0);
    send_req(CMD_HAY, "a", 1'b0);
    send_req(CMD_HAY, "b", 1'b1);
    send_req(CMD_NEEDLE, "c", 1'b0);
    send_req(CMD_HAY, "b", 1'b1);

    send_req(CMD_CLEAR, 8'h00, 1'b0);
    send_req(CMD_NEEDLE, 8'h00, 1'b0);
    send_req(CMD_NEEDLE, 8'hFF, 1'b0);
    send_req(CMD_UNUSED, 8'hA5, 1'b1);
    send_req(CMD_HAY, 8'h00, 1'b0);
    send_req(CMD_NEEDLE, "a", 1'b0);
    send_req(CMD_HAY, 8'hFF, 1'b0);

    send_req(CMD_CLEAR, 8'h5A, 1'b0);
    send_req(CMD_NEEDLE, "x", 1'b0);
    send_req(CMD_NEEDLE, "y", 1'b0);
    send_req(CMD_NEEDLE, "z", 1'b0);
    send_req(CMD_HAY, "x", 1'b0);
    send_req(CMD_HAY, "y", 1'b1);
  endtask

  // Needles at the length limit and just past it. The full-length needle is
  // planted after a short random prefix so the widest window must match.
  task automatic test_needle_limits();
    logic [SYM_W-1:0] pattern [NEEDLE_CAP];
    for (int i = 0; i < NEEDLE_CAP; i++) pattern[i] = pick_symbol(3);
    send_req(CMD_CLEAR, 8'h00, 1'b0);
    for (int i = 0; i < NEEDLE_CAP; i++) send_req(CMD_NEEDLE, pattern[i], 1'b0);
    for (int i = 0; i < 5; i++) send_req(CMD_HAY, pick_symbol(3), 1'b0);
    for (int i = 0; i < NEEDLE_CAP; i++)
      send_req(CMD_HAY, pattern[i], (i == NEEDLE_CAP - 1));

    // One byte too many: only the final haystack byte reports, flagged.
    send_req(CMD_CLEAR, 8'h00, 1'b0);
    for (int i = 0; i <= NEEDLE_CAP; i++) send_req(CMD_NEEDLE, pattern[i % NEEDLE_CAP], 1'b0);
    send_req(CMD_HAY, "a", 1'b0);
    send_req(CMD_HAY, "b", 1'b0);
    send_req(CMD_HAY, "c", 1'b1);

    // Overflowed search abandoned without a final byte; the clear must drop
    // the error flag for the next search.
    send_req(CMD_CLEAR, 8'h00, 1'b0);
    for (int i = 0; i < NEEDLE_CAP + 2; i++) send_req(CMD_NEEDLE, "a", 1'b0);
    send_req(CMD_HAY, "a", 1'b0);
    send_req(CMD_CLEAR, 8'h00, 1'b0);
    send_req(CMD_NEEDLE, "a", 1'b0);
    send_req(CMD_HAY, "a", 1'b1);
  endtask

  // One random search. Most are well formed (clear, needle, haystack ending
  // in last), with the needle often planted in the haystack. Some skip the
  // clear, some never send last, some send stray requests in the haystack or
  // after the search has closed.
  task automatic run_random_search();
    logic [SYM_W-1:0] pattern [$];
    logic [SYM_W-1:0] text [$];
    int unsigned n_len, h_len, alpha, pick, at;
    logic closes;
    pick = $urandom_range(0, 99);
    if (pick < 6) n_len = 0;
    else if (pick < 84) n_len = $urandom_range(1, 6);
    else if (pick < 94) n_len = $urandom_range(7, NEEDLE_CAP);
    else n_len = $urandom_range(NEEDLE_CAP + 1, NEEDLE_CAP + 4);
    alpha = $urandom_range(1, 4);
    h_len = $urandom_range(1, ((n_len > NEEDLE_CAP) ? NEEDLE_CAP : n_len) + 12);
    for (int i = 0; i < n_len; i++) pattern.push_back(pick_symbol(alpha));
    for (int i = 0; i < h_len; i++) text.push_back(pick_symbol(alpha));
    if (n_len != 0 && n_len <= NEEDLE_CAP && h_len >= n_len && $urandom_range(0, 1)) begin
      at = $urandom_range(0, h_len - n_len);
      for (int i = 0; i < n_len; i++) text[at + i] = pattern[i];
    end
    closes = ($urandom_range(0, 9) != 0);

    if ($urandom_range(0, 9) != 0)
      send_req(CMD_CLEAR, SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    foreach (pattern[i]) send_req(CMD_NEEDLE, pattern[i], 1'($urandom_range(0, 1)));
    foreach (text[i]) begin
      if ($urandom_range(0, 99) < 3)
        send_req($urandom_range(0, 1) ? CMD_UNUSED : CMD_NEEDLE,
                 SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_req(CMD_HAY, text[i], closes && (i == h_len - 1));
    end
    if ($urandom_range(0, 4) == 0)
      send_req(CMD_HAY, pick_symbol(alpha), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_searches(input int unsigned n_req);
    int unsigned target;
    target = requests_sent + n_req;
    while (requests_sent < target) run_random_search();
  endtask

  // ---------------------------------------------------------------------
  // Sequence: directed checks with no idling, then random searches under
  // each idling mix. Between phases the request side holds off until every
  // predicted result has come back.
  // ---------------------------------------------------------------------
  initial begin
    apply_reset();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_directed();
    test_needle_limits();
    await_all_results();

    test_random_searches(400);
    await_all_results();

    send_idle_pct = 61;
    test_random_searches(400);
    await_all_results();

    send_idle_pct = 0;
    recv_stall_pct = 61;
    test_random_searches(400);
    await_all_results();

    send_idle_pct = 34;
    recv_stall_pct = 34;
    test_random_searches(400);
    await_all_results();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
